[hdl/heat_stencil_sweep_defines.svh]
// Assertion macros shared by the heat stencil RTL.
`ifndef HEAT_STENCIL_SWEEP_DEFINES_SVH
`define HEAT_STENCIL_SWEEP_DEFINES_SVH

// Same-cycle implication.
`define HSS_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define HSS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/hss_pkg.sv]
// Shared constants, register codes and inter-stage types of the heat stencil.
`default_nettype none
package hss_pkg;

   localparam int TEMP_WIDTH     = 24;
   localparam int COEF_WIDTH     = 16;
   localparam int SIZE_WIDTH     = 10;
   localparam int POS_WIDTH      = 9;
   localparam int SUM_WIDTH      = 42;
   localparam int DIFF_WIDTH     = TEMP_WIDTH + 2;
   localparam int PROD_WIDTH     = DIFF_WIDTH + COEF_WIDTH + 1;
   localparam int TERM_WIDTH     = PROD_WIDTH - COEF_WIDTH;
   localparam int ADD3_WIDTH     = TERM_WIDTH + 2;
   localparam int CSR_ADDR_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int MAX_GRID_DEF   = 512;
   localparam int MIN_GRID       = 3;

   localparam logic [SIZE_WIDTH-1:0] GRID_SIZE_RST = SIZE_WIDTH'(512);
   localparam logic [COEF_WIDTH-1:0] COEF_RST      = COEF_WIDTH'(66);

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_GRID_SIZE = 2'd0,
      CSR_ROW_COEF  = 2'd1,
      CSR_COL_COEF  = 2'd2
   } csr_addr_type;

   typedef struct packed {
      logic                 emit_a;
      logic                 emit_b;
      logic                 interior;
      logic                 frame_end;
      logic [POS_WIDTH-1:0] row_a;
      logic [POS_WIDTH-1:0] row_b;
      logic [POS_WIDTH-1:0] col;
   } tag_type;

   typedef struct packed {
      tag_type                       tag;
      logic signed [TEMP_WIDTH-1:0]  south;
      logic signed [TEMP_WIDTH-1:0]  ctr;
      logic signed [DIFF_WIDTH-1:0]  vr;
      logic signed [DIFF_WIDTH-1:0]  vc;
   } grad_type;

   typedef struct packed {
      tag_type                       tag;
      logic signed [TEMP_WIDTH-1:0]  south;
      logic signed [TEMP_WIDTH-1:0]  val;
   } val_type;

endpackage
`default_nettype wire

[hdl/hss_ifs.sv]
// Valid/ready channel interfaces of the heat stencil block.
`default_nettype none
interface hss_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [hss_pkg::TEMP_WIDTH-1:0]  cell_temp;
   modport source (output valid, output cell_temp, input ready);
   modport sink   (input valid, input cell_temp, output ready);
endinterface

interface hss_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [hss_pkg::TEMP_WIDTH-1:0]  new_temp;
   logic [hss_pkg::POS_WIDTH-1:0]          out_row;
   logic [hss_pkg::POS_WIDTH-1:0]          out_col;
   logic                                   frame_last;
   logic signed [hss_pkg::SUM_WIDTH-1:0]   grid_sum;
   modport source (output valid, output new_temp, output out_row, output out_col,
                   output frame_last, output grid_sum, input ready);
   modport sink   (input valid, input new_temp, input out_row, input out_col,
                   input frame_last, input grid_sum, output ready);
endinterface

interface hss_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [hss_pkg::CSR_ADDR_WIDTH-1:0]    addr;
   logic [hss_pkg::CSR_DATA_WIDTH-1:0]    wdata;
   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface
`default_nettype wire

[hdl/hss_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read-first output.
`default_nettype none
module hss_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hdl/hss_front.sv]
// Raster counters, line RAMs, stencil window and second-difference stage.
`default_nettype none
`include "heat_stencil_sweep_defines.svh"
module hss_front #(
   parameter int MAX_GRID = hss_pkg::MAX_GRID_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   hss_req_if.sink                              req_if,
   input  wire logic [hss_pkg::SIZE_WIDTH-1:0]  grid_size,
   output      logic                            out_valid,
   output      hss_pkg::grad_type               out_data,
   input  wire logic                            out_ready
);

   localparam int CNT_W = $clog2(MAX_GRID);
   localparam int CMP_W = CNT_W + hss_pkg::SIZE_WIDTH + 1;
   localparam int POS_W = hss_pkg::POS_WIDTH;
   localparam int T     = hss_pkg::TEMP_WIDTH;
   localparam int D     = hss_pkg::DIFF_WIDTH;

   logic [CNT_W-1:0]       row_ff, row_in, col_ff, col_in, rowm1, east_addr;
   logic [CMP_W-1:0]       size_x, size_act, lim;
   logic                   last_row, last_col, accept, req_ready, ld2, mv2, up_wr;
   logic [T-1:0]           up_rd, mid_rd, east_rd;
   logic [CNT_W+POS_W-1:0] row_ext, rowm1_ext, col_ext;
   hss_pkg::tag_type       tag_in, tag1_ff;
   logic                   v1_ff, v2_ff;
   logic signed [T-1:0]    s1_ff, west_ff;
   logic [CNT_W-1:0]       col1_ff;
   logic signed [D-1:0]    north_x, south_x, ctr_x, west_x, east_x, vr, vc;
   hss_pkg::grad_type      grad_ff;

   // active side, clamped to [3, MAX_GRID]
   assign size_x = {{(CMP_W-hss_pkg::SIZE_WIDTH){1'b0}}, grid_size};
   always_comb begin
      priority if (size_x < CMP_W'(hss_pkg::MIN_GRID)) begin
         size_act = CMP_W'(hss_pkg::MIN_GRID);
      end else if (size_x > CMP_W'(MAX_GRID)) begin
         size_act = CMP_W'(MAX_GRID);
      end else begin
         size_act = size_x;
      end
   end
   assign lim      = size_act - CMP_W'(1);
   assign last_row = {{(CMP_W-CNT_W){1'b0}}, row_ff} >= lim;
   assign last_col = {{(CMP_W-CNT_W){1'b0}}, col_ff} >= lim;

   assign ld2       = !v2_ff || out_ready;
   assign req_ready = !v1_ff || ld2;
   assign accept    = req_if.valid && req_ready;
   assign mv2       = v1_ff && ld2;
   assign up_wr     = mv2 && tag1_ff.emit_a;
   assign req_if.ready = req_ready;

   always_comb begin
      col_in = col_ff + CNT_W'(1);
      row_in = row_ff;
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + CNT_W'(1);
      end
   end

   assign east_addr = last_col ? '0 : col_ff + CNT_W'(1);

   assign rowm1     = row_ff - CNT_W'(1);
   assign row_ext   = {{POS_W{1'b0}}, row_ff};
   assign rowm1_ext = {{POS_W{1'b0}}, rowm1};
   assign col_ext   = {{POS_W{1'b0}}, col_ff};

   always_comb begin
      tag_in.emit_a    = row_ff != '0;
      tag_in.emit_b    = last_row;
      tag_in.interior  = (row_ff > CNT_W'(1)) && (col_ff != '0) && !last_col;
      tag_in.frame_end = last_row && last_col;
      tag_in.row_a     = rowm1_ext[POS_W-1:0];
      tag_in.row_b     = row_ext[POS_W-1:0];
      tag_in.col       = col_ext[POS_W-1:0];
   end

   hss_ram #(.WIDTH(T), .DEPTH(MAX_GRID)) u_upper (
      .clock   (clock),
      .wr_en   (up_wr),
      .wr_addr (col1_ff),
      .wr_data (mid_rd),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (up_rd)
   );

   // middle line kept twice: centre and east are read at different columns
   hss_ram #(.WIDTH(T), .DEPTH(MAX_GRID)) u_mid_ctr (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (req_if.cell_temp),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (mid_rd)
   );

   hss_ram #(.WIDTH(T), .DEPTH(MAX_GRID)) u_mid_east (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (req_if.cell_temp),
      .rd_en   (accept),
      .rd_addr (east_addr),
      .rd_data (east_rd)
   );

   assign north_x = {{2{up_rd[T-1]}}, up_rd};
   assign south_x = {{2{s1_ff[T-1]}}, s1_ff};
   assign ctr_x   = {{2{mid_rd[T-1]}}, mid_rd};
   assign west_x  = {{2{west_ff[T-1]}}, west_ff};
   assign east_x  = {{2{east_rd[T-1]}}, east_rd};
   assign vr      = north_x + south_x - (ctr_x <<< 1);
   assign vc      = west_x + east_x - (ctr_x <<< 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
      end else begin
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         if (req_ready) begin
            v1_ff <= req_if.valid;
         end
         if (ld2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff   <= req_if.cell_temp;
         col1_ff <= col_ff;
         tag1_ff <= tag_in;
      end
      if (mv2) begin
         west_ff       <= mid_rd;
         grad_ff.tag   <= tag1_ff;
         grad_ff.south <= s1_ff;
         grad_ff.ctr   <= mid_rd;
         grad_ff.vr    <= vr;
         grad_ff.vc    <= vc;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = grad_ff;

   `HSS_ASSERT_NOW(a_upper_no_clash, clock, reset, up_wr && accept, col1_ff != col_ff, "upper line write hits the column being read")
   `HSS_ASSERT_NEXT(a_frame_wrap, clock, reset, accept && last_row && last_col, (row_ff == '0) && (col_ff == '0), "raster position did not wrap at grid end")

endmodule
`default_nettype wire

[hdl/hss_math.sv]
// Coefficient multiply stage and the add/saturate stage.
`default_nettype none
module hss_math (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [hss_pkg::COEF_WIDTH-1:0]  row_coef,
   input  wire logic [hss_pkg::COEF_WIDTH-1:0]  col_coef,
   input  wire logic                            in_valid,
   input  wire hss_pkg::grad_type               in_data,
   output      logic                            in_ready,
   output      logic                            out_valid,
   output      hss_pkg::val_type                out_data,
   input  wire logic                            out_ready
);

   localparam int T  = hss_pkg::TEMP_WIDTH;
   localparam int C  = hss_pkg::COEF_WIDTH;
   localparam int P  = hss_pkg::PROD_WIDTH;
   localparam int TW = hss_pkg::TERM_WIDTH;
   localparam int AW = hss_pkg::ADD3_WIDTH;

   typedef struct packed {
      hss_pkg::tag_type     tag;
      logic signed [T-1:0]  south;
      logic signed [T-1:0]  ctr;
      logic signed [TW-1:0] tr;
      logic signed [TW-1:0] tc;
   } term_type;

   logic                 v3_ff, v4_ff, ld3, ld4;
   logic signed [C:0]    rc_s, cc_s;
   logic signed [P-1:0]  pr, pc;
   term_type             t3_ff;
   hss_pkg::val_type     v4d_ff;
   logic signed [AW-1:0] sum3;
   logic [AW-T:0]        upper;
   logic signed [T-1:0]  sat, val;

   assign ld4      = !v4_ff || out_ready;
   assign ld3      = !v3_ff || ld4;
   assign in_ready = ld3;

   assign rc_s = $signed({1'b0, row_coef});
   assign cc_s = $signed({1'b0, col_coef});
   assign pr   = in_data.vr * rc_s;
   assign pc   = in_data.vc * cc_s;

   // centre plus the two terms, each floor-shifted by the coefficient fraction
   assign sum3 = {{(AW-T){t3_ff.ctr[T-1]}}, t3_ff.ctr}
               + {{(AW-TW){t3_ff.tr[TW-1]}}, t3_ff.tr}
               + {{(AW-TW){t3_ff.tc[TW-1]}}, t3_ff.tc};
   assign upper = sum3[AW-1:T-1];

   always_comb begin
      if ((upper == '0) || (&upper)) begin
         sat = sum3[T-1:0];
      end else if (sum3[AW-1]) begin
         sat = {1'b1, {(T-1){1'b0}}};
      end else begin
         sat = {1'b0, {(T-1){1'b1}}};
      end
   end
   assign val = t3_ff.tag.interior ? sat : t3_ff.ctr;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (ld3) begin
            v3_ff <= in_valid;
         end
         if (ld4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && ld3) begin
         t3_ff.tag   <= in_data.tag;
         t3_ff.south <= in_data.south;
         t3_ff.ctr   <= in_data.ctr;
         t3_ff.tr    <= pr[P-1:C];
         t3_ff.tc    <= pc[P-1:C];
      end
      if (v3_ff && ld4) begin
         v4d_ff.tag   <= t3_ff.tag;
         v4d_ff.south <= t3_ff.south;
         v4d_ff.val   <= val;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = v4d_ff;

endmodule
`default_nettype wire

[hdl/hss_emit.sv]
// Grid sum accumulation and the output register that sends up to two words per cell.
`default_nettype none
`include "heat_stencil_sweep_defines.svh"
module hss_emit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire hss_pkg::val_type  in_data,
   output      logic              in_ready,
   hss_rsp_if.source              rsp_if
);

   localparam int T  = hss_pkg::TEMP_WIDTH;
   localparam int S  = hss_pkg::SUM_WIDTH;
   localparam int PW = hss_pkg::POS_WIDTH;

   logic                ha_ff, hb_ff, last_ff, load, pop, busy;
   logic signed [T-1:0] a_val_ff, b_val_ff;
   logic [PW-1:0]       row_a_ff, row_b_ff, col_ff;
   logic signed [S-1:0] acc_ff, acc_in, total, sum_ff, add_a, add_b;

   assign busy     = ha_ff || hb_ff;
   assign in_ready = !busy || (rsp_if.ready && !(ha_ff && hb_ff));
   assign load     = in_valid && in_ready;
   assign pop      = rsp_if.valid && rsp_if.ready;

   assign add_a  = in_data.tag.emit_a ? {{(S-T){in_data.val[T-1]}}, in_data.val} : '0;
   assign add_b  = in_data.tag.emit_b ? {{(S-T){in_data.south[T-1]}}, in_data.south} : '0;
   assign total  = acc_ff + add_a + add_b;
   assign acc_in = in_data.tag.frame_end ? '0 : total;

   always_ff @(posedge clock) begin
      if (reset) begin
         ha_ff  <= 1'b0;
         hb_ff  <= 1'b0;
         acc_ff <= '0;
      end else if (load) begin
         ha_ff  <= in_data.tag.emit_a;
         hb_ff  <= in_data.tag.emit_b;
         acc_ff <= acc_in;
      end else if (pop) begin
         if (ha_ff) begin
            ha_ff <= 1'b0;
         end else begin
            hb_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         a_val_ff <= in_data.val;
         b_val_ff <= in_data.south;
         row_a_ff <= in_data.tag.row_a;
         row_b_ff <= in_data.tag.row_b;
         col_ff   <= in_data.tag.col;
         last_ff  <= in_data.tag.frame_end;
         sum_ff   <= total;
      end
   end

   assign rsp_if.valid      = busy;
   assign rsp_if.new_temp   = ha_ff ? a_val_ff : b_val_ff;
   assign rsp_if.out_row    = ha_ff ? row_a_ff : row_b_ff;
   assign rsp_if.out_col    = col_ff;
   assign rsp_if.frame_last = !ha_ff && last_ff;
   assign rsp_if.grid_sum   = (!ha_ff && last_ff) ? sum_ff : '0;

   `HSS_ASSERT_NEXT(a_acc_clear, clock, reset, load && in_data.tag.frame_end, acc_ff == '0, "grid sum not cleared after the last cell")
   `HSS_ASSERT_NEXT(a_pair_order, clock, reset, pop && ha_ff && hb_ff, !ha_ff && hb_ff, "second word of a cell lost or reordered")

endmodule
`default_nettype wire

[hdl/heat_stencil_sweep.sv]
// Heat stencil top level: configuration registers and the stencil pipeline.
//
// One explicit step of the 2D heat equation with a five-point stencil. Cells stream in raster
// order as signed Q11.12 words, one per clock unless the output holds them back; the updated cell
// one row up leaves the front, math and emit registers after the cell that completes its window
// is accepted. The output port moves one word a clock while it is ready, so on the last row, where
// each input cell also produces its own border word, intake waits while both words of a cell are
// pending. Three line RAMs of MAX_GRID words hold the two previous rows (the middle row is kept
// twice for its two read columns); they need no clearing after reset. grid_size (clamped to
// 3..MAX_GRID), row_coef and col_coef are written through the csr port while the block is idle,
// a rule for the user that the block itself does not enforce. The final word of a grid carries
// frame_last and the Q29.12 sum of the new grid.
`default_nettype none
module heat_stencil_sweep #(
   parameter int MAX_GRID = hss_pkg::MAX_GRID_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   hss_req_if.sink   req_if,
   hss_rsp_if.source rsp_if,
   hss_csr_if.sink   csr_if
);

   logic [hss_pkg::SIZE_WIDTH-1:0] grid_size_ff;
   logic [hss_pkg::COEF_WIDTH-1:0] row_coef_ff, col_coef_ff;
   logic                           grad_valid, grad_ready, val_valid, val_ready;
   hss_pkg::grad_type              grad_data;
   hss_pkg::val_type               val_data;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= hss_pkg::GRID_SIZE_RST;
         row_coef_ff  <= hss_pkg::COEF_RST;
         col_coef_ff  <= hss_pkg::COEF_RST;
      end else if (csr_if.valid) begin
         unique case (hss_pkg::csr_addr_type'(csr_if.addr))
            hss_pkg::CSR_GRID_SIZE: begin
               grid_size_ff <= csr_if.wdata[hss_pkg::SIZE_WIDTH-1:0];
            end
            hss_pkg::CSR_ROW_COEF: begin
               row_coef_ff <= csr_if.wdata;
            end
            hss_pkg::CSR_COL_COEF: begin
               col_coef_ff <= csr_if.wdata;
            end
            default: begin
            end
         endcase
      end
   end

   hss_front #(.MAX_GRID(MAX_GRID)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .grid_size (grid_size_ff),
      .out_valid (grad_valid),
      .out_data  (grad_data),
      .out_ready (grad_ready)
   );

   hss_math u_math (
      .clock     (clock),
      .reset     (reset),
      .row_coef  (row_coef_ff),
      .col_coef  (col_coef_ff),
      .in_valid  (grad_valid),
      .in_data   (grad_data),
      .in_ready  (grad_ready),
      .out_valid (val_valid),
      .out_data  (val_data),
      .out_ready (val_ready)
   );

   hss_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .in_valid (val_valid),
      .in_data  (val_data),
      .in_ready (val_ready),
      .rsp_if   (rsp_if)
   );

endmodule
`default_nettype wire
